// ----- rtl/core/sovl_pkg.sv -----
// shared types and constants of the stereo sound output stage
// used by every module of the block; no dependencies

package sovl_pkg;

  // request type codes
  localparam logic ReqControl = 1'b0;
  localparam logic ReqFrame   = 1'b1;

  // output mode codes (value 3 acts as normal)
  localparam logic [1:0] ModeNormal = 2'd0;
  localparam logic [1:0] ModeRepeat = 2'd1;
  localparam logic [1:0] ModeZero   = 2'd2;

  // control byte bit positions
  localparam int unsigned BitMute    = 4;
  localparam int unsigned BitLowpass = 3;
  localparam int unsigned BitClock   = 2;
  localparam int unsigned BitData    = 1;
  localparam int unsigned BitStrobe  = 0;

  // serial volume interface
  localparam logic [3:0] SelStart  = 4'd3;
  localparam logic [3:0] VolStart  = 4'd5;
  localparam logic [3:0] FrameBits = 4'd11;
  localparam logic [3:0] CountCap  = 4'd12;
  localparam logic [5:0] MaxAtten  = 6'd43;

  // request queue
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = 1;
  localparam int unsigned FifoCntW  = 2;

  // 1 - ln(v)/ln(43) in q24, rounded to nearest, v = 0 is unity
  localparam logic [24:0] GainQ24 [44] = '{
    25'd16777216, 25'd16777216, 25'd13685362, 25'd11876744, 25'd10593509, 25'd9598154,
    25'd8784890,  25'd8097286,  25'd7501655,  25'd6976272,  25'd6506301,  25'd6081160,
    25'd5693037,  25'd5335998,  25'd5005432,  25'd4697682,  25'd4409802,  25'd4139379,
    25'd3884419,  25'd3643246,  25'd3414447,  25'd3196814,  25'd2989306,  25'd2791025,
    25'd2601183,  25'd2419093,  25'd2244145,  25'd2075800,  25'd1913579,  25'd1757050,
    25'd1605829,  25'd1459567,  25'd1317948,  25'd1180688,  25'd1047526,  25'd918224,
    25'd792565,   25'd670349,   25'd551393,   25'd435526,   25'd322594,   25'd212450,
    25'd104960,   25'd0
  };

  // one queued frame request with the settings in force when it was taken
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               buf_end;
    logic               dbl;
    logic               zero_fill;
    logic               mute;
    logic               lowpass;
    logic [5:0]         att_l;
    logic [5:0]         att_r;
  } frame_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ----- rtl/core/stereo_sound_out_volume_lowpass_unit.sv -----
// order: a frame's result leaves through the queue and the back's registers,
// a double mode's repeat or zero frame after it; control writes give no result
// throughput: the back issues one frame per cycle unless the queue is empty or
// the output stalls, two per request in double modes; a 2-entry queue decouples
// reset (rst_ni, async, active low): flags, volumes, interface, filter history,
// mode and all valid bits clear; the queue and pipeline come up empty

module stereo_sound_out_volume_lowpass_unit #(
  parameter int unsigned GAIN_FRAC_BITS = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration: output mode
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [7:0]         control_byte_i,
  input  logic signed [15:0] left_sample_i,
  input  logic signed [15:0] right_sample_i,
  input  logic               buffer_end_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  output logic               last_o,
  output logic               buffer_end_out_o
);

  // front to queue
  logic                   push;
  sovl_pkg::frame_req_t   push_data;
  // queue to back
  logic                   pop;
  sovl_pkg::frame_req_t   head;
  sovl_pkg::fifo_status_t fifo_status;

  // front: control byte decode, serial volume shift register, frame tagging
  // each queued frame carries the mute, lowpass and volume settings that were
  // in force when it arrived, so later control writes never reach back
  sovl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .control_byte_i (control_byte_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .buffer_end_i   (buffer_end_i),
    .fifo_status_i  (fifo_status),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  // request queue, the front keeps taking requests while results wait, until it is full
  sovl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (fifo_status)
  );

  // back: frame expansion, 1-2-1 lowpass, gain multiply, truncation to zero
  // a muted frame or a frame with both volumes zero and no lowpass leaves the
  // filter history alone; unity gain at zero volume keeps samples exact
  sovl_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .fifo_status_i    (fifo_status),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .left_out_o       (left_out_o),
    .right_out_o      (right_out_o),
    .last_o           (last_o),
    .buffer_end_out_o (buffer_end_out_o)
  );

  // buffer end is only ever flagged on the final result of a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && buffer_end_out_o |-> last_o)
    else $error("buffer end flagged on a non-final result");

  // the back never takes a request from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_status.empty)
    else $error("queue read while empty");

  // a full queue stalls the front, so no request is written into it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_status.full && !pop |=> fifo_status.full)
    else $error("queue lost an entry while full");

endmodule

// ----- rtl/core/sovl_front.sv -----
// front part: takes requests, runs the control byte and serial volume logic
// and turns sample frames into queued frame requests; uses sovl_pkg

module sovl_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [7:0]            control_byte_i,
  input  logic signed [15:0]    left_sample_i,
  input  logic signed [15:0]    right_sample_i,
  input  logic                  buffer_end_i,
  input  sovl_pkg::fifo_status_t fifo_status_i,
  output logic                  push_o,
  output sovl_pkg::frame_req_t  push_data_o
);

  logic       mode_q;
  logic [1:0] mode_val_q;
  logic       mute_q, mute_d;
  logic       lp_q, lp_d;
  logic [5:0] att_l_q, att_l_d;
  logic [5:0] att_r_q, att_r_d;
  logic       prev_clk_q, prev_clk_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] sel_q, sel_d;
  logic [5:0] vol_q, vol_d;
  logic       accept;
  logic       ctrl_accept;
  logic       bit_clk;
  logic       bit_dat;
  logic [5:0] vol_clamped;

  assign in_stall_o  = fifo_status_i.full;
  assign accept      = in_valid_i & ~in_stall_o;
  assign ctrl_accept = accept & (req_type_i == sovl_pkg::ReqControl);
  assign push_o      = accept & (req_type_i == sovl_pkg::ReqFrame);

  assign bit_clk     = control_byte_i[sovl_pkg::BitClock];
  assign bit_dat     = control_byte_i[sovl_pkg::BitData];
  assign vol_clamped = (vol_q > sovl_pkg::MaxAtten) ? sovl_pkg::MaxAtten : vol_q;

  always_comb begin
    mute_d     = mute_q;
    lp_d       = lp_q;
    att_l_d    = att_l_q;
    att_r_d    = att_r_q;
    prev_clk_d = prev_clk_q;
    cnt_d      = cnt_q;
    sel_d      = sel_q;
    vol_d      = vol_q;
    if (ctrl_accept) begin
      mute_d     = control_byte_i[sovl_pkg::BitMute];
      lp_d       = control_byte_i[sovl_pkg::BitLowpass];
      prev_clk_d = bit_clk;
      if (control_byte_i[sovl_pkg::BitStrobe]) begin
        // commit only after a complete frame of bits
        if (cnt_q == sovl_pkg::FrameBits) begin
          if (sel_q[0]) begin
            att_l_d = vol_clamped;
          end
          if (sel_q[1]) begin
            att_r_d = vol_clamped;
          end
        end
      end else if (bit_clk && !prev_clk_q) begin
        if (cnt_q < sovl_pkg::SelStart) begin
          sel_d = sel_q;
        end else if (cnt_q < sovl_pkg::VolStart) begin
          sel_d = {sel_q[0], bit_dat};
        end else if (cnt_q < sovl_pkg::FrameBits) begin
          vol_d = {vol_q[4:0], bit_dat};
        end
        if (cnt_q < sovl_pkg::CountCap) begin
          cnt_d = cnt_q + 4'd1;
        end
      end else if (bit_clk == prev_clk_q) begin
        // repeated clock level resets the interface
        cnt_d = '0;
        sel_d = '0;
        vol_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      mode_val_q <= sovl_pkg::ModeNormal;
      mute_q     <= 1'b0;
      lp_q       <= 1'b0;
      att_l_q    <= '0;
      att_r_q    <= '0;
      prev_clk_q <= 1'b0;
      cnt_q      <= '0;
      sel_q      <= '0;
      vol_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_val_q <= cfg_wdata_i;
        mode_q     <= (cfg_wdata_i == sovl_pkg::ModeRepeat) ||
                      (cfg_wdata_i == sovl_pkg::ModeZero);
      end
      mute_q     <= mute_d;
      lp_q       <= lp_d;
      att_l_q    <= att_l_d;
      att_r_q    <= att_r_d;
      prev_clk_q <= prev_clk_d;
      cnt_q      <= cnt_d;
      sel_q      <= sel_d;
      vol_q      <= vol_d;
    end
  end

  always_comb begin
    push_data_o.left      = left_sample_i;
    push_data_o.right     = right_sample_i;
    push_data_o.buf_end   = buffer_end_i;
    push_data_o.dbl       = mode_q;
    push_data_o.zero_fill = (mode_val_q == sovl_pkg::ModeZero);
    push_data_o.mute      = mute_q;
    push_data_o.lowpass   = lp_q;
    push_data_o.att_l     = att_l_q;
    push_data_o.att_r     = att_r_q;
  end

endmodule

// ----- rtl/core/sovl_fifo.sv -----
// short request queue between the front and back parts
// uses sovl_pkg for the entry type and depth

module sovl_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sovl_pkg::frame_req_t   push_data_i,
  input  logic                   pop_i,
  output sovl_pkg::frame_req_t   head_o,
  output sovl_pkg::fifo_status_t status_o
);

  sovl_pkg::frame_req_t mem_q [sovl_pkg::FifoDepth];
  logic [sovl_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [sovl_pkg::FifoCntW-1:0] cnt_q;

  function automatic logic [sovl_pkg::FifoPtrW-1:0] ptr_inc(
    input logic [sovl_pkg::FifoPtrW-1:0] p
  );
    if (p == sovl_pkg::FifoPtrW'(sovl_pkg::FifoDepth - 1)) begin
      return '0;
    end
    return p + sovl_pkg::FifoPtrW'(1);
  endfunction

  assign status_o.full  = (cnt_q == sovl_pkg::FifoCntW'(sovl_pkg::FifoDepth));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + sovl_pkg::FifoCntW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - sovl_pkg::FifoCntW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/sovl_back.sv -----
// back part: expands queued requests into frames, runs lowpass and gain
// three register stages to the output; uses sovl_pkg

module sovl_back #(
  parameter int unsigned GAIN_FRAC_BITS = 15
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sovl_pkg::frame_req_t   head_i,
  input  sovl_pkg::fifo_status_t fifo_status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [15:0]     left_out_o,
  output logic signed [15:0]     right_out_o,
  output logic                   last_o,
  output logic                   buffer_end_out_o
);

  localparam int unsigned GW = GAIN_FRAC_BITS + 1;
  localparam int unsigned PW = 16 + GW + 1;
  localparam int unsigned GainShift = 24 - GAIN_FRAC_BITS;
  localparam logic [24:0] RoundBias = 25'(1) << (23 - GAIN_FRAC_BITS);
  localparam logic [PW-1:0] TruncBias = PW'((1 << GAIN_FRAC_BITS) - 1);

  function automatic logic [GW-1:0] gain_of(input logic [5:0] att);
    logic [5:0]  idx;
    logic [24:0] sum;
    idx = (att > sovl_pkg::MaxAtten) ? sovl_pkg::MaxAtten : att;
    sum = sovl_pkg::GainQ24[idx] + RoundBias;
    return GW'(sum >> GainShift);
  endfunction

  function automatic logic signed [15:0] lp_filter(
    input logic signed [15:0] x,
    input logic signed [15:0] h0,
    input logic signed [15:0] h1
  );
    logic signed [17:0] s;
    s = 18'(h0) + (18'(h1) <<< 1) + 18'(x);
    return 16'(s >>> 2);
  endfunction

  function automatic logic signed [15:0] trunc_zero(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + (p[PW-1] ? $signed(TruncBias) : $signed(PW'(0)));
    return 16'(t >>> GAIN_FRAC_BITS);
  endfunction

  logic               en;
  logic               issue;
  logic               sub_q;
  logic               frame_last;
  logic               hist_upd;
  logic signed [15:0] x_l, x_r, y_l, y_r;
  logic signed [15:0] hist_l_q [2];
  logic signed [15:0] hist_r_q [2];

  // stage 1: filtered samples and gains
  logic               s1_valid_q;
  logic signed [15:0] s1_x_l_q, s1_x_r_q;
  logic [GW-1:0]      s1_g_l_q, s1_g_r_q;
  logic               s1_last_q, s1_bend_q;

  // stage 2: products
  logic                 s2_valid_q;
  logic signed [PW-1:0] s2_p_l_q, s2_p_r_q;
  logic                 s2_last_q, s2_bend_q;
  logic signed [PW-1:0] prod_l, prod_r;

  logic out_valid_q;

  // the whole pipe moves unless the output holds a stalled result
  assign en         = ~out_valid_q | ~out_stall_i;
  assign issue      = en & ~fifo_status_i.empty;
  assign frame_last = ~head_i.dbl | sub_q;
  assign pop_o      = issue & frame_last;
  assign hist_upd   = issue & head_i.lowpass & ~head_i.mute;

  always_comb begin
    x_l = head_i.left;
    x_r = head_i.right;
    if (sub_q && head_i.zero_fill) begin
      x_l = '0;
      x_r = '0;
    end
    y_l = x_l;
    y_r = x_r;
    if (head_i.mute) begin
      y_l = '0;
      y_r = '0;
    end else if (head_i.lowpass) begin
      y_l = lp_filter(x_l, hist_l_q[0], hist_l_q[1]);
      y_r = lp_filter(x_r, hist_r_q[0], hist_r_q[1]);
    end
  end

  assign prod_l = s1_x_l_q * $signed({1'b0, s1_g_l_q});
  assign prod_r = s1_x_r_q * $signed({1'b0, s1_g_r_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= 1'b0;
      hist_l_q[0] <= '0;
      hist_l_q[1] <= '0;
      hist_r_q[0] <= '0;
      hist_r_q[1] <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        sub_q <= ~frame_last;
      end
      if (hist_upd) begin
        hist_l_q[0] <= hist_l_q[1];
        hist_l_q[1] <= x_l;
        hist_r_q[0] <= hist_r_q[1];
        hist_r_q[1] <= x_r;
      end
      if (en) begin
        s1_valid_q  <= issue;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_l_q         <= y_l;
      s1_x_r_q         <= y_r;
      s1_g_l_q         <= gain_of(head_i.att_l);
      s1_g_r_q         <= gain_of(head_i.att_r);
      s1_last_q        <= frame_last;
      s1_bend_q        <= frame_last & head_i.buf_end;
      s2_p_l_q         <= prod_l;
      s2_p_r_q         <= prod_r;
      s2_last_q        <= s1_last_q;
      s2_bend_q        <= s1_bend_q;
      left_out_o       <= trunc_zero(s2_p_l_q);
      right_out_o      <= trunc_zero(s2_p_r_q);
      last_o           <= s2_last_q;
      buffer_end_out_o <= s2_bend_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sim/tb_stereo_sound_out_volume_lowpass_unit.sv -----
// testbench for the stereo sound output stage: volume, mute, lowpass, double modes
// self-checking against an in-file predictor; needs sovl_pkg and the unit's rtl
`timescale 1ns / 100ps

module tb_stereo_sound_out_volume_lowpass_unit;

  // gain precision handed to the unit and used by the predictor
  localparam int unsigned GainFracBits = 15;
  // the spare mode value behaves like normal mode
  localparam logic [1:0] ModeUnused = 2'd3;
  // settle time after the last result before a register write or the end
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned ReportLimit = 10;

  // 1 - ln(v)/ln(43) in q24, v = 0 is unity
  localparam int unsigned AttenGainQ24 [44] = '{
    16777216, 16777216, 13685362, 11876744, 10593509, 9598154,
    8784890,  8097286,  7501655,  6976272,  6506301,  6081160,
    5693037,  5335998,  5005432,  4697682,  4409802,  4139379,
    3884419,  3643246,  3414447,  3196814,  2989306,  2791025,
    2601183,  2419093,  2244145,  2075800,  1913579,  1757050,
    1605829,  1459567,  1317948,  1180688,  1047526,  918224,
    792565,   670349,   551393,   435526,   322594,   212450,
    104960,   0
  };

  // one request as offered on the input channel
  typedef struct packed {
    logic               kind;
    logic [7:0]         ctrl;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               buf_end;
  } audio_req_t;

  // one processed frame as it should leave the unit
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
    logic               buf_end;
  } sound_frame_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_wdata_i = sovl_pkg::ModeNormal;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = sovl_pkg::ReqControl;
  logic [7:0]         control_byte_i = '0;
  logic signed [15:0] left_sample_i = '0;
  logic signed [15:0] right_sample_i = '0;
  logic               buffer_end_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] left_out_o;
  logic signed [15:0] right_out_o;
  logic               last_o;
  logic               buffer_end_out_o;

  // predictor state, mirrors the unit after reset
  logic [1:0]         mode_q = sovl_pkg::ModeNormal;
  logic               mute_q = 1'b0;
  logic               lowpass_q = 1'b0;
  logic [5:0]         att_l_q = '0;
  logic [5:0]         att_r_q = '0;
  logic [7:0]         held_ctrl = '0;
  logic [3:0]         shift_q = '0;
  logic [1:0]         sel_q = '0;
  logic [5:0]         vol_q = '0;
  logic signed [15:0] hist_l [2] = '{default: '0};
  logic signed [15:0] hist_r [2] = '{default: '0};

  sound_frame_t sound_frames_due [$];
  int unsigned  request_count = 0;
  int unsigned  bad_frames = 0;
  int unsigned  cycle_count = 0;
  // idling control shared by both sides; calm switches all idling off
  int unsigned  idle_pct = 0;
  logic         calm = 1'b0;

  stereo_sound_out_volume_lowpass_unit #(
    .GAIN_FRAC_BITS(GainFracBits)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .control_byte_i  (control_byte_i),
    .left_sample_i   (left_sample_i),
    .right_sample_i  (right_sample_i),
    .buffer_end_i    (buffer_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_out_o      (left_out_o),
    .right_out_o     (right_out_o),
    .last_o          (last_o),
    .buffer_end_out_o(buffer_end_out_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // sample times the q-format gain of an attenuation step, truncated toward zero
  function automatic logic signed [15:0] scale(input logic signed [15:0] x,
                                               input logic [5:0] att);
    logic [5:0] idx;
    longint     g;
    longint     p;
    idx = (att > sovl_pkg::MaxAtten) ? sovl_pkg::MaxAtten : att;
    // round the q24 entry to the unit's gain precision
    g = (longint'(AttenGainQ24[idx]) + (longint'(1) << (23 - GainFracBits)))
        >>> (24 - GainFracBits);
    p = longint'(x) * g;
    if (p < 0) begin
      p = -((-p) >>> GainFracBits);
    end else begin
      p = p >>> GainFracBits;
    end
    return p[15:0];
  endfunction

  // 1-2-1 lowpass tap, floor of the quarter sum
  function automatic logic signed [15:0] smooth(input logic signed [15:0] x, h_old, h_new);
    int s;
    s = (int'(h_old) + 2 * int'(h_new) + int'(x)) >>> 2;
    return s[15:0];
  endfunction

  // one emitted frame through mute, filter and gain
  function automatic void shape_frame(input logic signed [15:0] l, r,
                                      output logic signed [15:0] lo, ro);
    logic signed [15:0] fl;
    logic signed [15:0] fr;
    fl = l;
    fr = r;
    if (mute_q) begin
      lo = '0;
      ro = '0;
    end else if (att_l_q != 0 || att_r_q != 0 || lowpass_q) begin
      if (lowpass_q) begin
        fl = smooth(l, hist_l[0], hist_l[1]);
        fr = smooth(r, hist_r[0], hist_r[1]);
        // history keeps the unfiltered input
        hist_l[0] = hist_l[1];
        hist_l[1] = l;
        hist_r[0] = hist_r[1];
        hist_r[1] = r;
      end
      lo = scale(fl, att_l_q);
      ro = scale(fr, att_r_q);
    end else begin
      // both volumes zero and no filter: straight through, history untouched
      lo = l;
      ro = r;
    end
  endfunction

  // control byte: flags plus one step of the serial volume interface
  function automatic void apply_control(input logic [7:0] b);
    logic [5:0] v;
    mute_q    = b[sovl_pkg::BitMute];
    lowpass_q = b[sovl_pkg::BitLowpass];
    if (b[sovl_pkg::BitStrobe]) begin
      // commit only after exactly one full word
      if (shift_q == sovl_pkg::FrameBits) begin
        v = (vol_q > sovl_pkg::MaxAtten) ? sovl_pkg::MaxAtten : vol_q;
        if (sel_q[0]) att_l_q = v;
        if (sel_q[1]) att_r_q = v;
      end
    end else if (b[sovl_pkg::BitClock] && !held_ctrl[sovl_pkg::BitClock]) begin
      // rising clock shifts one data bit
      if (shift_q >= sovl_pkg::SelStart && shift_q < sovl_pkg::VolStart) begin
        sel_q = {sel_q[0], b[sovl_pkg::BitData]};
      end else if (shift_q >= sovl_pkg::VolStart && shift_q < sovl_pkg::FrameBits) begin
        vol_q = {vol_q[4:0], b[sovl_pkg::BitData]};
      end
      if (shift_q < sovl_pkg::CountCap) shift_q = shift_q + 4'd1;
    end else if (b[sovl_pkg::BitClock] == held_ctrl[sovl_pkg::BitClock]) begin
      // clock level held without strobe restarts the word
      shift_q = '0;
      sel_q   = '0;
      vol_q   = '0;
    end
    held_ctrl = b;
  endfunction

  // an accepted request: update state and queue the frames it must produce
  function automatic void process_sound_request(input audio_req_t rq);
    sound_frame_t f;
    logic signed [15:0] l2;
    logic signed [15:0] r2;
    if (rq.kind == sovl_pkg::ReqControl) begin
      apply_control(rq.ctrl);
    end else if (mode_q == sovl_pkg::ModeRepeat || mode_q == sovl_pkg::ModeZero) begin
      shape_frame(rq.left, rq.right, f.left, f.right);
      f.last    = 1'b0;
      f.buf_end = 1'b0;
      sound_frames_due.push_back(f);
      // second copy: the same frame again or silence, both through the filter
      l2 = (mode_q == sovl_pkg::ModeZero) ? 16'sd0 : rq.left;
      r2 = (mode_q == sovl_pkg::ModeZero) ? 16'sd0 : rq.right;
      shape_frame(l2, r2, f.left, f.right);
      f.last    = 1'b1;
      f.buf_end = rq.buf_end;
      sound_frames_due.push_back(f);
    end else begin
      shape_frame(rq.left, rq.right, f.left, f.right);
      f.last    = 1'b1;
      f.buf_end = rq.buf_end;
      sound_frames_due.push_back(f);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall bursts and the checker
  // ---------------------------------------------------------------------------

  initial begin : result_pacing
    int unsigned span;
    forever begin
      @(posedge clk_i);
      span = $urandom_range(10, 1);
      if (!calm && $urandom_range(99, 0) < idle_pct) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        // now and then a long stretch with no stall at all
        if ($urandom_range(3, 0) == 0) span = $urandom_range(40, 10);
      end
      repeat (span - 1) @(posedge clk_i);
    end
  end

  task automatic log_mismatch(input string msg);
    bad_frames++;
    if (bad_frames <= ReportLimit) $display("%0t: %s", $realtime, msg);
  endtask

  // compare each accepted result with the oldest predicted frame
  always @(posedge clk_i) begin : result_check
    sound_frame_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sound_frames_due.size() == 0) begin
        log_mismatch($sformatf("result with none due: l=%0d r=%0d last=%0b end=%0b",
                               left_out_o, right_out_o, last_o, buffer_end_out_o));
      end else begin
        want = sound_frames_due.pop_front();
        if (want.left !== left_out_o || want.right !== right_out_o ||
            want.last !== last_o || want.buf_end !== buffer_end_out_o) begin
          log_mismatch($sformatf(
            "frame mismatch: want l=%0d r=%0d last=%0b end=%0b, got l=%0d r=%0d last=%0b end=%0b",
            want.left, want.right, want.last, want.buf_end,
            left_out_o, right_out_o, last_o, buffer_end_out_o));
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one request, hold it until taken, then predict; valid stays high
  // so a back-to-back request does not drop it for a step
  task automatic send_request(input audio_req_t rq);
    if (!calm && $urandom_range(99, 0) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= rq.kind;
    control_byte_i <= rq.ctrl;
    left_sample_i  <= rq.left;
    right_sample_i <= rq.right;
    buffer_end_i   <= rq.buf_end;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    process_sound_request(rq);
    request_count++;
  endtask

  // unused fields carry random values; the unit must ignore them
  task automatic send_control(input logic [7:0] b);
    audio_req_t rq;
    rq.kind    = sovl_pkg::ReqControl;
    rq.ctrl    = b;
    rq.left    = 16'($urandom());
    rq.right   = 16'($urandom());
    rq.buf_end = 1'($urandom());
    send_request(rq);
  endtask

  task automatic send_frame(input logic signed [15:0] l, r, input logic buf_end);
    audio_req_t rq;
    rq.kind    = sovl_pkg::ReqFrame;
    rq.ctrl    = 8'($urandom());
    rq.left    = l;
    rq.right   = r;
    rq.buf_end = buf_end;
    send_request(rq);
  endtask

  function automatic logic [7:0] ctrl_byte(input logic [7:3] flags,
                                           input logic clk_lvl, data, strobe);
    logic [7:0] b;
    b                      = {flags, 3'b000};
    b[sovl_pkg::BitClock]  = clk_lvl;
    b[sovl_pkg::BitData]   = data;
    b[sovl_pkg::BitStrobe] = strobe;
    return b;
  endfunction

  // serial volume word: restart, nbits rising clocks, strobe; a glitch index
  // inserts a held clock level after that bit, which restarts the word
  task automatic serial_write(input logic [7:3] flags, input logic [1:0] chan,
                              input logic [5:0] vol, input int unsigned nbits,
                              input int glitch);
    logic [12:0] word;
    // three ignored bits, channel, volume, then spare bits past the word
    word = {3'($urandom()), chan, vol, 2'($urandom())};
    send_control(ctrl_byte(flags, 1'b0, 1'($urandom()), 1'b0));
    send_control(ctrl_byte(flags, 1'b0, 1'($urandom()), 1'b0));
    for (int i = 0; i < nbits; i++) begin
      send_control(ctrl_byte(flags, 1'b1, word[12 - i], 1'b0));
      send_control(ctrl_byte(flags, 1'b0, 1'($urandom()), 1'b0));
      if (i == glitch) send_control(ctrl_byte(flags, 1'b0, 1'($urandom()), 1'b0));
    end
    send_control(ctrl_byte(flags, 1'($urandom()), 1'($urandom()), 1'b1));
  endtask

  // let everything drain before a register write or the end
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sound_frames_due.size() != 0) @(posedge clk_i);
    // a trailing control write may still be in flight with nothing due
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_output_mode(input logic [1:0] mode);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_q = mode;
  endtask

  function automatic logic [7:3] rand_flags();
    logic [7:3] f;
    f                       = 5'($urandom());
    f[sovl_pkg::BitMute]    = ($urandom_range(99, 0) < 15);
    f[sovl_pkg::BitLowpass] = 1'($urandom());
    return f;
  endfunction

  function automatic logic [5:0] rand_volume();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 25) return 6'd0;
    if (pick < 40) return 6'($urandom_range(63, 43));
    return 6'($urandom());
  endfunction

  function automatic logic signed [15:0] rand_sample();
    if ($urandom_range(99, 0) < 15) begin
      case ($urandom_range(4, 0))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return 16'sh0000;
        3: return 16'shffff;
        default: return 16'sh0001;
      endcase
    end
    return 16'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset state: unity volumes, no filter, frames pass unchanged
  task automatic test_passthrough();
    send_frame(16'sh7fff, 16'sh8000, 1'b1);
    send_frame(16'sh8000, 16'sh7fff, 1'b0);
    send_frame(16'sh0000, 16'shffff, 1'b1);
    send_frame(16'shffff, 16'sh0000, 1'b0);
  endtask

  // mute silences frames; lowpass steps across the full range
  task automatic test_mute_lowpass();
    logic [7:3] mute_only;
    logic [7:3] lp_only;
    mute_only = '0;
    mute_only[sovl_pkg::BitMute] = 1'b1;
    lp_only = '0;
    lp_only[sovl_pkg::BitLowpass] = 1'b1;
    send_control(ctrl_byte(mute_only, 1'b0, 1'b0, 1'b0));
    send_frame(16'sh7fff, 16'sh8000, 1'b1);
    send_control(ctrl_byte(lp_only, 1'b0, 1'b0, 1'b0));
    repeat (3) send_frame(16'sh7fff, 16'sh7fff, 1'b0);
    repeat (3) send_frame(16'sh8000, 16'sh8000, 1'b1);
    send_control(ctrl_byte('0, 1'b0, 1'b0, 1'b0));
    send_frame(16'sh1234, 16'shedcc, 1'b0);
  endtask

  // full-range volume words, clamping and a return to unity
  task automatic test_volume_commit();
    serial_write('0, 2'b11, 6'd43, 11, -1);
    send_frame(16'sh7fff, 16'sh8000, 1'b0);
    serial_write('0, 2'b01, 6'd63, 11, -1);
    serial_write('0, 2'b10, 6'd1, 11, -1);
    send_frame(16'sh8000, 16'sh7fff, 1'b1);
    send_frame(16'sh3039, 16'shcfc7, 1'b0);
    serial_write('0, 2'b11, 6'd0, 11, -1);
    send_frame(16'sh8000, 16'sh7fff, 1'b1);
  endtask

  // double modes and the spare mode value, with the filter running
  task automatic test_output_modes();
    logic [7:3] lp_only;
    logic [1:0] modes [3];
    lp_only = '0;
    lp_only[sovl_pkg::BitLowpass] = 1'b1;
    modes = '{sovl_pkg::ModeRepeat, sovl_pkg::ModeZero, ModeUnused};
    foreach (modes[k]) begin
      set_output_mode(modes[k]);
      send_control(ctrl_byte(lp_only, 1'b0, 1'b0, 1'b0));
      send_frame(16'sh7fff, 16'sh8000, 1'b1);
      send_frame(16'sh8000, 16'sh7fff, 1'b0);
    end
  endtask

  // mostly clean volume words and frame bursts, some broken words and noise
  task automatic test_random_traffic(input logic [1:0] mode, input int unsigned n_items,
                                     input int unsigned pct);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned nbits;
    int          glitch;
    set_output_mode(mode);
    idle_pct = pct;
    stop_at = request_count + n_items;
    while (request_count < stop_at) begin
      pick = $urandom_range(99, 0);
      if (pick < 20) begin
        serial_write(rand_flags(), 2'($urandom()), rand_volume(), 11, -1);
      end else if (pick < 28) begin
        // short, long or interrupted word
        nbits  = $urandom_range(13, 0);
        glitch = ($urandom_range(1, 0) == 1) ? int'($urandom_range(12, 0)) : -1;
        serial_write(rand_flags(), 2'($urandom()), rand_volume(), nbits, glitch);
      end else if (pick < 35) begin
        send_control(8'($urandom()));
      end else begin
        repeat ($urandom_range(12, 1)) send_frame(rand_sample(), rand_sample(), 1'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 30;
    test_passthrough();
    test_mute_lowpass();
    test_volume_commit();
    test_output_modes();

    test_random_traffic(sovl_pkg::ModeRepeat, 220, 30);
    test_random_traffic(sovl_pkg::ModeZero, 220, 50);
    test_random_traffic(ModeUnused, 120, 20);
    test_random_traffic(sovl_pkg::ModeNormal, 210, 40);
    // closing stretch at full rate on both sides
    calm = 1'b1;
    test_random_traffic(sovl_pkg::ModeRepeat, 110, 0);

    wait_drained();
    if (bad_frames == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
